FILE: hw/rtl/pci_pkg.sv
// Shared types and constants of the pillar corner interpolation block.
package pci_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W = 48;
	localparam int DIF_W = VAL_W + 1;
	localparam int THR_W = 47;
	localparam int TAG_W = 3;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'((2 ** FRAC_BITS) / 100);

	// Multiplier split and divider sizes.
	localparam int HALF_W = 25;
	localparam int PP_W = 2 * HALF_W;
	localparam int PROD_W = 2 * DIF_W;
	localparam int REM_W = DIF_W;
	localparam int QCAP_LOG = 50;
	localparam int QB = QCAP_LOG + 1;

	localparam int LANES = 2;
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 64;

	typedef enum logic {
		REG_VERT_THR = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [TAG_W-1:0] corner_tag;
		logic signed [VAL_W-1:0] top_x;
		logic signed [VAL_W-1:0] top_y;
		logic signed [VAL_W-1:0] top_z;
		logic signed [VAL_W-1:0] bottom_x;
		logic signed [VAL_W-1:0] bottom_y;
		logic signed [VAL_W-1:0] bottom_z;
		logic signed [VAL_W-1:0] corner_z;
	} in_item_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag_out;
		logic signed [VAL_W-1:0] corner_x;
		logic signed [VAL_W-1:0] corner_y;
		logic flat_pillar;
	} out_item_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [LANES-1:0][VAL_W-1:0] top;
		logic [LANES-1:0] neg;
		logic [LANES-1:0] ovf;
		logic flat;
		logic [REM_W-1:0] divisor;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QB-1:0] quo;
		logic [QB-1:0] num;
	} lane_t;

	typedef struct packed {
		logic valid;
		side_t side;
		lane_t [LANES-1:0] lane;
	} cell_t;

endpackage

FILE: hw/rtl/pci_if.sv
// Stream interfaces for corner items in and interpolated corners out.
interface pci_in_if;
	import pci_pkg::*;
	logic valid;
	logic ready;
	in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface pci_out_if;
	import pci_pkg::*;
	logic valid;
	logic ready;
	out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pillar_corner_interpolation_top.sv
// Top level of the pillar corner interpolation block.
//
// Channel     Dir   Handshake       Carries
// corner_in   in    valid/ready     one cell corner with its pillar's top and bottom
// corner_out  out   valid/ready     interpolated corner x, y, flat flag and tag
// APB         in    psel/penable    vertical threshold register at index 0
//
// One corner per cycle is taken while the skid stage is empty; each passes through
// five front stages, a chain of 51 divider cells with one quotient bit per cell,
// and the output register. The divider chain makes up most of the pipeline.
// Reset clears the valid bits and loads the threshold with 0.01 in Q16.
// When the output is stalled, a skid stage catches one transaction and
// corner_in.ready drops until it drains.
module pillar_corner_interpolation_top (
	input logic clk,
	input logic arst_n,
	pci_in_if.sink corner_in,
	pci_out_if.source corner_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pci_pkg::ADDR_W-1:0] paddr,
	input logic [pci_pkg::DATA_W-1:0] pwdata,
	output logic [pci_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import pci_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic en;
	cell_t chain [0:QB];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite
				&& paddr[ADDR_W-1] == REG_VERT_THR) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[ADDR_W-1]))
			REG_VERT_THR: begin
				prdata = DATA_W'(thr_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign corner_in.ready = en;

	pci_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(corner_in.valid),
		.in_item(corner_in.payload),
		.thr(thr_q),
		.head(chain[0])
	);

	for (genvar i = 0; i < QB; i++) begin : g_cell
		pci_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.cin(chain[i]),
			.cout(chain[i+1])
		);
	end

	pci_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.cin(chain[QB]),
		.dout(corner_out),
		.en(en)
	);

endmodule

FILE: hw/rtl/pci_front.sv
// Front pipeline: differences, magnitudes, split products and divider setup.
module pci_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input pci_pkg::in_item_t in_item,
	input logic [pci_pkg::THR_W-1:0] thr,
	output pci_pkg::cell_t head
);
	import pci_pkg::*;

	function automatic logic [DIF_W-1:0] sdiff(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		sdiff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
	endfunction

	function automatic logic [DIF_W-1:0] magn(input logic [DIF_W-1:0] v);
		magn = v[DIF_W-1] ? (~v + DIF_W'(1)) : v;
	endfunction

	function automatic logic [PP_W-1:0] mulh(input logic [HALF_W-1:0] a,
			input logic [HALF_W-1:0] b);
		mulh = PP_W'(a) * PP_W'(b);
	endfunction

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4;
	logic [LANES-1:0][VAL_W-1:0] top_s1, top_s2, top_s3, top_s4;
	logic [DIF_W-1:0] dz_s1, dzc_s1;
	logic [LANES-1:0][DIF_W-1:0] dt_s1;

	logic [DIF_W-1:0] magdz_s2, magdzc_s2;
	logic [LANES-1:0][DIF_W-1:0] magdt_s2;
	logic [LANES-1:0] neg_s2, neg_s3, neg_s4;

	logic [DIF_W-1:0] div_s3, div_s4;
	logic flat_s3, flat_s4;
	logic [LANES-1:0][PP_W-1:0] pp00_s3, pp01_s3, pp10_s3, pp11_s3;

	logic [LANES-1:0][PROD_W-1:0] prod_s4;

	side_t side_s5;
	lane_t [LANES-1:0] lane_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Exact 49-bit differences.
			tag_s1 <= in_item.corner_tag;
			top_s1[LANE_X] <= in_item.top_x;
			top_s1[LANE_Y] <= in_item.top_y;
			dz_s1 <= sdiff(in_item.bottom_z, in_item.top_z);
			dzc_s1 <= sdiff(in_item.corner_z, in_item.top_z);
			dt_s1[LANE_X] <= sdiff(in_item.top_x, in_item.bottom_x);
			dt_s1[LANE_Y] <= sdiff(in_item.top_y, in_item.bottom_y);

			// Magnitudes and the sign of the quotient.
			tag_s2 <= tag_s1;
			top_s2 <= top_s1;
			magdz_s2 <= magn(dz_s1);
			magdzc_s2 <= magn(dzc_s1);
			for (int l = 0; l < LANES; l++) begin
				magdt_s2[l] <= magn(dt_s1[l]);
				neg_s2[l] <= dzc_s1[DIF_W-1] ^ dt_s1[l][DIF_W-1] ^ dz_s1[DIF_W-1];
			end

			// Four partial products per lane.
			tag_s3 <= tag_s2;
			top_s3 <= top_s2;
			neg_s3 <= neg_s2;
			div_s3 <= magdz_s2;
			flat_s3 <= !(magdz_s2 > DIF_W'(thr));
			for (int l = 0; l < LANES; l++) begin
				pp00_s3[l] <= mulh(magdzc_s2[HALF_W-1:0], magdt_s2[l][HALF_W-1:0]);
				pp01_s3[l] <= mulh(magdzc_s2[HALF_W-1:0],
					HALF_W'(magdt_s2[l][DIF_W-1:HALF_W]));
				pp10_s3[l] <= mulh(HALF_W'(magdzc_s2[DIF_W-1:HALF_W]),
					magdt_s2[l][HALF_W-1:0]);
				pp11_s3[l] <= mulh(HALF_W'(magdzc_s2[DIF_W-1:HALF_W]),
					HALF_W'(magdt_s2[l][DIF_W-1:HALF_W]));
			end

			// The outer products do not overlap, so they concatenate.
			tag_s4 <= tag_s3;
			top_s4 <= top_s3;
			neg_s4 <= neg_s3;
			div_s4 <= div_s3;
			flat_s4 <= flat_s3;
			for (int l = 0; l < LANES; l++) begin
				prod_s4[l] <= {pp11_s3[l][PROD_W-PP_W-1:0], pp00_s3[l]}
					+ (PROD_W'(PP_W'(pp01_s3[l]) + PP_W'(pp10_s3[l])) << HALF_W)
					+ (PROD_W'(pp01_s3[l][PP_W-1] & pp10_s3[l][PP_W-1]) << PP_W)
					+ (PROD_W'((pp01_s3[l][PP_W-1] ^ pp10_s3[l][PP_W-1])
						& ~(PP_W'(pp01_s3[l]) + PP_W'(pp10_s3[l]) >= pp01_s3[l]))
						<< (HALF_W + PP_W));
			end

			// A quotient of 2^51 or more is known from the high dividend bits alone;
			// the low bits are left for the divider cells.
			side_s5.tag <= tag_s4;
			side_s5.top <= top_s4;
			side_s5.neg <= neg_s4;
			side_s5.flat <= flat_s4;
			side_s5.divisor <= div_s4;
			for (int l = 0; l < LANES; l++) begin
				side_s5.ovf[l] <= REM_W'(prod_s4[l][PROD_W-1:QB]) >= div_s4;
				lane_s5[l].rem <= REM_W'(prod_s4[l][PROD_W-1:QB]);
				lane_s5[l].quo <= '0;
				lane_s5[l].num <= prod_s4[l][QB-1:0];
			end
		end
	end

	always_comb begin
		head.valid = valid_s5;
		head.side = side_s5;
		head.lane = lane_s5;
	end

endmodule

FILE: hw/rtl/pci_div_cell.sv
// One restoring division step for both lanes, registered toward the next cell.
module pci_div_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input pci_pkg::cell_t cin,
	output pci_pkg::cell_t cout
);
	import pci_pkg::*;

	logic [LANES-1:0][REM_W:0] trial;
	logic [LANES-1:0][REM_W:0] sub;
	logic [LANES-1:0] ge;
	lane_t [LANES-1:0] lane_n;
	logic valid_q;
	side_t side_q;
	lane_t [LANES-1:0] lane_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {cin.lane[l].rem, cin.lane[l].num[QB-1]};
			ge[l] = trial[l] >= {1'b0, cin.side.divisor};
			sub[l] = trial[l] - {1'b0, cin.side.divisor};
			lane_n[l].rem = ge[l] ? sub[l][REM_W-1:0] : trial[l][REM_W-1:0];
			lane_n[l].quo = {cin.lane[l].quo[QB-2:0], ge[l]};
			lane_n[l].num = {cin.lane[l].num[QB-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= cin.side;
			lane_q <= lane_n;
		end
	end

	assign cout.valid = valid_q;
	assign cout.side = side_q;
	assign cout.lane = lane_q;

endmodule

FILE: hw/rtl/pci_out.sv
// Final add and saturation, output register and skid stage.
module pci_out (
	input logic clk,
	input logic arst_n,
	input pci_pkg::cell_t cin,
	pci_out_if.source dout,
	output logic en
);
	import pci_pkg::*;

	localparam int SUM_W = QB + 2;
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

	function automatic logic [VAL_W-1:0] place(input logic [VAL_W-1:0] top,
			input logic [QB-1:0] quo, input logic ovf, input logic neg);
		logic [SUM_W-1:0] q;
		logic [SUM_W-1:0] t;
		logic [SUM_W-1:0] s;
		q = ovf ? (SUM_W'(1) << QCAP_LOG) : SUM_W'(quo);
		t = {{(SUM_W - VAL_W){top[VAL_W-1]}}, top};
		s = neg ? (t + q) : (t - q);
		if ((&s[SUM_W-1:VAL_W-1]) || !(|s[SUM_W-1:VAL_W-1])) begin
			place = s[VAL_W-1:0];
		end else begin
			place = s[SUM_W-1] ? VAL_MIN : VAL_MAX;
		end
	endfunction

	out_item_t res;
	out_item_t out_q, sk_q;
	logic out_valid_q, sk_valid_q;

	always_comb begin
		res.tag_out = cin.side.tag;
		res.flat_pillar = cin.side.flat;
		if (cin.side.flat) begin
			res.corner_x = cin.side.top[LANE_X];
			res.corner_y = cin.side.top[LANE_Y];
		end else begin
			res.corner_x = place(cin.side.top[LANE_X], cin.lane[LANE_X].quo,
				cin.side.ovf[LANE_X], cin.side.neg[LANE_X]);
			res.corner_y = place(cin.side.top[LANE_Y], cin.lane[LANE_Y].quo,
				cin.side.ovf[LANE_Y], cin.side.neg[LANE_Y]);
		end
	end

	// The chain only moves while the skid stage is empty.
	assign en = !sk_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (dout.ready) begin
				sk_valid_q <= 1'b0;
			end
		end else if (cin.valid) begin
			if (!out_valid_q || dout.ready) begin
				out_valid_q <= 1'b1;
			end else begin
				sk_valid_q <= 1'b1;
			end
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (dout.ready) begin
				out_q <= sk_q;
			end
		end else if (cin.valid) begin
			if (!out_valid_q || dout.ready) begin
				out_q <= res;
			end else begin
				sk_q <= res;
			end
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.payload = out_q;

endmodule

FILE: hw/rtl/pci_checker.sv
// Port-level assertions for the pillar corner interpolation block.
module pci_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pci_pkg::out_item_t out_payload,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pci_pkg::ADDR_W-1:0] paddr,
	input logic [pci_pkg::DATA_W-1:0] pwdata,
	input logic [pci_pkg::DATA_W-1:0] prdata
);
	import pci_pkg::*;

	// A stalled result stays and does not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("output transaction changed while stalled");

	// Input is only refused while a result is waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// Once the output is taken, the skid stage drains and input ready returns in the next cycle.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("input ready did not return after output transaction");

	// A threshold write reads back on the next cycle.
	a_thr_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[ADDR_W-1] == REG_VERT_THR
		|=> !(psel && !pwrite && paddr[ADDR_W-1] == REG_VERT_THR)
			|| prdata == DATA_W'($past(pwdata[THR_W-1:0])))
		else $error("threshold read back mismatch");

endmodule

bind pillar_corner_interpolation_top pci_checker u_pci_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(corner_in.ready),
	.out_valid(corner_out.valid),
	.out_ready(corner_out.ready),
	.out_payload(corner_out.payload),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);
